@@ src/pca_pkg.sv @@
`default_nettype none
package pca_pkg;

	localparam int COLOR_W = 8;
	localparam int PIXEL_W = 3 * COLOR_W;
	localparam int SQ_W    = 2 * COLOR_W;
	localparam int DIST_W  = SQ_W + 2;
	localparam int INDEX_W = 8;
	localparam int USED_W  = 9;

	localparam logic [1:0] CMD_MAP     = 2'd0;
	localparam logic [1:0] CMD_NEAREST = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam logic [1:0] KIND_EXACT   = 2'd0;
	localparam logic [1:0] KIND_NEW     = 2'd1;
	localparam logic [1:0] KIND_NEAREST = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESOLVE,
		ST_EMIT
	} pca_state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic resolve;
		logic out_load;
	} pca_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic addr_last;
		logic pipe_busy;
	} pca_status_t;

endpackage
`default_nettype wire

@@ src/palette_color_allocator_core.sv @@
// Channel   Handshake            Payload
// input     in_valid / in_ready  command, color_red, color_green, color_blue
// output    out_valid/ out_ready palette_index, match_kind, entries_used
//
// A scanning command reads every entry in use, at most PALETTE_DEPTH, waits for the
// compare pipeline to drain, then resolves and loads the output register.
// The scan reads one stored entry per cycle through the single RAM read port.
// Clear, unused codes and commands on an empty palette skip the scan and go straight
// to resolve. In both cases the next transaction is accepted once the result is loaded.
// After reset the palette holds black at entry 0 and no clearing pass is needed.
// A result waiting in the output register does not block acceptance of the next
// transaction, which then holds in its final state until the output register is free.
`default_nettype none
module palette_color_allocator_core #(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  command,
	input  wire logic [pca_pkg::COLOR_W-1:0] color_red,
	input  wire logic [pca_pkg::COLOR_W-1:0] color_green,
	input  wire logic [pca_pkg::COLOR_W-1:0] color_blue,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [pca_pkg::INDEX_W-1:0] palette_index,
	output logic      [1:0]                  match_kind,
	output logic      [pca_pkg::USED_W-1:0]  entries_used
);
	import pca_pkg::*;

	pca_cmd_t    cmd;
	pca_status_t status;

	pca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	pca_dp #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.command       (command),
		.color_red     (color_red),
		.color_green   (color_green),
		.color_blue    (color_blue),
		.palette_index (palette_index),
		.match_kind    (match_kind),
		.entries_used  (entries_used)
	);

endmodule
`default_nettype wire

@@ src/pca_ram.sv @@
`default_nettype none
module pca_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ src/pca_ctrl.sv @@
`default_nettype none
module pca_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire pca_pkg::pca_status_t status,
	output pca_pkg::pca_cmd_t         cmd
);
	import pca_pkg::*;

	pca_state_t state_q;
	pca_state_t state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.need_scan ? ST_SCAN : ST_RESOLVE;
				end
			end
			ST_SCAN: begin
				if (status.addr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_RESOLVE;
				end
			end
			ST_RESOLVE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_RESOLVE: begin
				cmd.resolve = 1'b1;
			end
			ST_EMIT: begin
				cmd.out_load = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ src/pca_dp.sv @@
`default_nettype none
module pca_dp #(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pca_pkg::pca_cmd_t             cmd,
	output pca_pkg::pca_status_t               status,
	input  wire logic [1:0]                    command,
	input  wire logic [pca_pkg::COLOR_W-1:0]   color_red,
	input  wire logic [pca_pkg::COLOR_W-1:0]   color_green,
	input  wire logic [pca_pkg::COLOR_W-1:0]   color_blue,
	output logic      [pca_pkg::INDEX_W-1:0]   palette_index,
	output logic      [1:0]                    match_kind,
	output logic      [pca_pkg::USED_W-1:0]    entries_used
);
	import pca_pkg::*;

	localparam int IDX_W = $clog2(PALETTE_DEPTH);
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

	logic [1:0]         cmd_q;
	logic [PIXEL_W-1:0] want_q;
	logic [CNT_W-1:0]   count_q;
	logic               entry0_ok_q;
	logic [IDX_W-1:0]   addr_q;

	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [PIXEL_W-1:0] rd_data;
	logic [PIXEL_W-1:0] pix;

	logic               v_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [SQ_W-1:0]    sq_r_s2;
	logic [SQ_W-1:0]    sq_g_s2;
	logic [SQ_W-1:0]    sq_b_s2;

	logic [COLOR_W-1:0] diff_r;
	logic [COLOR_W-1:0] diff_g;
	logic [COLOR_W-1:0] diff_b;
	logic [DIST_W-1:0]  dist_sum;

	logic               best_v_q;
	logic [DIST_W-1:0]  best_d_q;
	logic [IDX_W-1:0]   best_idx_q;

	logic               full;
	logic               wr_en;
	logic [IDX_W-1:0]   res_idx_d;
	logic [1:0]         res_kind_d;
	logic [IDX_W-1:0]   res_idx_q;
	logic [1:0]         res_kind_q;

	pca_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (PALETTE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (want_q),
		.rd_en   (cmd.scan),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	assign status.need_scan = ((command == CMD_MAP) || (command == CMD_NEAREST))
		&& (count_q != '0);
	assign status.addr_last = (CNT_W'(addr_q) + CNT_W'(1)) == count_q;
	assign status.pipe_busy = v_s1 || v_s2;

	assign pix = ((idx_s1 == '0) && !entry0_ok_q) ? '0 : rd_data;

	always_comb begin
		diff_r = (pix[23:16] > want_q[23:16]) ? pix[23:16] - want_q[23:16]
			: want_q[23:16] - pix[23:16];
		diff_g = (pix[15:8] > want_q[15:8]) ? pix[15:8] - want_q[15:8]
			: want_q[15:8] - pix[15:8];
		diff_b = (pix[7:0] > want_q[7:0]) ? pix[7:0] - want_q[7:0]
			: want_q[7:0] - pix[7:0];
		dist_sum = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
	end

	assign full = count_q >= CNT_W'(PALETTE_DEPTH);

	always_comb begin
		wr_en      = 1'b0;
		res_idx_d  = '0;
		res_kind_d = KIND_NONE;
		case (cmd_q)
			CMD_MAP: begin
				if (best_v_q && (best_d_q == '0)) begin
					res_idx_d  = best_idx_q;
					res_kind_d = KIND_EXACT;
				end else if (!full) begin
					wr_en      = cmd.resolve;
					res_idx_d  = count_q[IDX_W-1:0];
					res_kind_d = KIND_NEW;
				end else begin
					res_idx_d  = best_idx_q;
					res_kind_d = KIND_NEAREST;
				end
			end
			CMD_NEAREST: begin
				if (best_v_q) begin
					res_idx_d  = best_idx_q;
					res_kind_d = KIND_NEAREST;
				end
			end
			default: begin
				res_kind_d = KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CNT_W'(1);
			entry0_ok_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			best_v_q    <= 1'b0;
			addr_q      <= '0;
		end else begin
			v_s1 <= cmd.scan;
			v_s2 <= v_s1;
			if (cmd.load) begin
				addr_q   <= '0;
				best_v_q <= 1'b0;
			end else if (cmd.scan) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			if (v_s2 && (!best_v_q || (dist_sum < best_d_q))) begin
				best_v_q <= 1'b1;
			end
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
				if (count_q == '0) begin
					entry0_ok_q <= 1'b1;
				end
			end else if (cmd.resolve && (cmd_q == CMD_CLEAR)) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			want_q <= {color_red, color_green, color_blue};
		end
		idx_s1  <= addr_q;
		idx_s2  <= idx_s1;
		sq_r_s2 <= SQ_W'(diff_r) * SQ_W'(diff_r);
		sq_g_s2 <= SQ_W'(diff_g) * SQ_W'(diff_g);
		sq_b_s2 <= SQ_W'(diff_b) * SQ_W'(diff_b);
		if (v_s2 && (!best_v_q || (dist_sum < best_d_q))) begin
			best_d_q   <= dist_sum;
			best_idx_q <= idx_s2;
		end
		if (cmd.resolve) begin
			res_idx_q  <= res_idx_d;
			res_kind_q <= res_kind_d;
		end
		if (cmd.out_load) begin
			palette_index <= INDEX_W'(res_idx_q);
			match_kind    <= res_kind_q;
			entries_used  <= USED_W'(count_q);
		end
	end

endmodule
`default_nettype wire

@@ src/pca_chk.sv @@
`default_nettype none
module pca_chk #(
	parameter int PALETTE_DEPTH = 256
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [pca_pkg::INDEX_W-1:0] palette_index,
	input wire logic [1:0]                  match_kind,
	input wire logic [pca_pkg::USED_W-1:0]  entries_used
);
	import pca_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(palette_index)
		&& $stable(match_kind) && $stable(entries_used))
		else $error("Result changed while the output transaction was stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("A second transaction was accepted before the first was processed.");

	a_none_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (match_kind == KIND_NONE) |-> palette_index == '0)
		else $error("A result of kind none carries a non-zero index.");

	a_new_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (match_kind == KIND_NEW)
		|-> entries_used == ({1'b0, palette_index} + USED_W'(1)))
		else $error("A newly allocated entry is not the last entry in use.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entries_used <= USED_W'(PALETTE_DEPTH))
		else $error("Entries in use exceed the palette depth.");

endmodule

bind palette_color_allocator_core pca_chk #(
	.PALETTE_DEPTH (PALETTE_DEPTH)
) u_pca_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.palette_index (palette_index),
	.match_kind    (match_kind),
	.entries_used  (entries_used)
);
`default_nettype wire

@@ tb/palette_color_allocator_core_tb.sv @@
`timescale 1ns / 100ps
module palette_color_allocator_core_tb;
	import pca_pkg::*;

	localparam int PALETTE_DEPTH = 256;
	localparam int TOTAL_COMMANDS = 1550;
	localparam int CALM_TAIL = 120;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int DIRECTED_ROWS = 22;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [1:0]         kind;
		logic [USED_W-1:0]  used;
	} palette_reply_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [PIXEL_W-1:0] rgb;
		logic               fixed;
		palette_reply_t     reply;
	} directed_row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         command = CMD_MAP;
	logic [COLOR_W-1:0] color_red = '0;
	logic [COLOR_W-1:0] color_green = '0;
	logic [COLOR_W-1:0] color_blue = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [INDEX_W-1:0] palette_index;
	logic [1:0]         match_kind;
	logic [USED_W-1:0]  entries_used;

	logic [PIXEL_W-1:0] shadow_palette [PALETTE_DEPTH];
	int unsigned        shadow_count = 1;
	palette_reply_t     expected_matches [$];
	directed_row_t      directed_rows [DIRECTED_ROWS];
	bit                 pacing_on = 1'b0;
	int unsigned        cycle_count = 0;
	int unsigned        error_count = 0;
	int unsigned        commands_sent = 0;
	int unsigned        fills_completed = 0;
	int unsigned        kind_tally [4];

	palette_color_allocator_core #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.color_red    (color_red),
		.color_green  (color_green),
		.color_blue   (color_blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.palette_index(palette_index),
		.match_kind   (match_kind),
		.entries_used (entries_used)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("palette_color_allocator_core_tb failed");
		$finish;
	end

	function automatic int unsigned color_distance(logic [PIXEL_W-1:0] a, logic [PIXEL_W-1:0] b);
		int dr;
		int dg;
		int db;
		dr = int'(a[2*COLOR_W +: COLOR_W]) - int'(b[2*COLOR_W +: COLOR_W]);
		dg = int'(a[COLOR_W +: COLOR_W]) - int'(b[COLOR_W +: COLOR_W]);
		db = int'(a[0 +: COLOR_W]) - int'(b[0 +: COLOR_W]);
		return dr * dr + dg * dg + db * db;
	endfunction

	function automatic int unsigned nearest_entry(logic [PIXEL_W-1:0] rgb);
		int unsigned best;
		int unsigned best_dist;
		int unsigned cand_dist;
		int unsigned i;
		best = 0;
		best_dist = color_distance(shadow_palette[0], rgb);
		for (i = 1; i < shadow_count; i++) begin
			cand_dist = color_distance(shadow_palette[i], rgb);
			if (cand_dist < best_dist) begin
				best = i;
				best_dist = cand_dist;
			end
		end
		return best;
	endfunction

	function automatic palette_reply_t palette_response(logic [1:0] cmd, logic [PIXEL_W-1:0] rgb);
		palette_reply_t reply;
		int unsigned hit;
		int unsigned i;
		reply.index = '0;
		reply.kind = KIND_NONE;
		hit = shadow_count;
		case (cmd)
			CMD_MAP: begin
				for (i = 0; i < shadow_count; i++)
					if (hit == shadow_count && shadow_palette[i] == rgb)
						hit = i;
				if (hit < shadow_count) begin
					reply.index = INDEX_W'(hit);
					reply.kind = KIND_EXACT;
				end else if (shadow_count < PALETTE_DEPTH) begin
					shadow_palette[shadow_count] = rgb;
					reply.index = INDEX_W'(shadow_count);
					reply.kind = KIND_NEW;
					shadow_count++;
					if (shadow_count == PALETTE_DEPTH)
						fills_completed++;
				end else begin
					reply.index = INDEX_W'(nearest_entry(rgb));
					reply.kind = KIND_NEAREST;
				end
			end
			CMD_NEAREST: begin
				if (shadow_count > 0) begin
					reply.index = INDEX_W'(nearest_entry(rgb));
					reply.kind = KIND_NEAREST;
				end
			end
			CMD_CLEAR: begin
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		reply.used = USED_W'(shadow_count);
		return reply;
	endfunction

	function automatic logic [PIXEL_W-1:0] random_color(bit coarse);
		logic [PIXEL_W-1:0] rgb;
		rgb = PIXEL_W'($urandom);
		if (coarse)
			rgb = rgb & 24'hF0F0F0;
		return rgb;
	endfunction

	function automatic logic [PIXEL_W-1:0] jittered_entry();
		logic [PIXEL_W-1:0] rgb;
		int c;
		int k;
		if (shadow_count == 0)
			return PIXEL_W'($urandom);
		rgb = shadow_palette[$urandom_range(0, shadow_count - 1)];
		for (k = 0; k < 3; k++) begin
			c = int'(rgb[k*COLOR_W +: COLOR_W]) + int'($urandom_range(0, 6)) - 3;
			if (c < 0)
				c = 0;
			if (c > 255)
				c = 255;
			rgb[k*COLOR_W +: COLOR_W] = COLOR_W'(c);
		end
		return rgb;
	endfunction

	task automatic next_random_command(input bit filling, input bit coarse,
			output logic [1:0] cmd, output logic [PIXEL_W-1:0] rgb);
		int roll;
		roll = $urandom_range(0, 99);
		cmd = CMD_MAP;
		rgb = random_color(coarse);
		if (roll < 62) begin
		end else if (roll < 75) begin
			if (shadow_count != 0)
				rgb = shadow_palette[$urandom_range(0, shadow_count - 1)];
		end else if (roll < 82) begin
			rgb = jittered_entry();
		end else if (roll < 93) begin
			cmd = CMD_NEAREST;
			if (roll[0])
				rgb = jittered_entry();
			else if (coarse)
				rgb = rgb | 24'h080808;
		end else if (roll < 96) begin
			cmd = CMD_UNUSED;
		end else if (!filling) begin
			cmd = CMD_CLEAR;
		end else begin
			cmd = CMD_NEAREST;
		end
	endtask

	task automatic issue_command(logic [1:0] cmd, logic [PIXEL_W-1:0] rgb, bit fixed,
			palette_reply_t fixed_reply);
		palette_reply_t predicted;
		if ($urandom_range(0, 49) == 0)
			pacing_on = !pacing_on;
		if (commands_sent + CALM_TAIL >= TOTAL_COMMANDS)
			pacing_on = 1'b0;
		if (pacing_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		{color_red, color_green, color_blue} <= rgb;
		do @(posedge clk); while (!in_ready);
		predicted = palette_response(cmd, rgb);
		expected_matches.push_back(fixed ? fixed_reply : predicted);
		commands_sent++;
	endtask

	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pacing_on && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 12);
				out_ready <= 1'b0;
				repeat (hold - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		palette_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			kind_tally[match_kind]++;
			if (expected_matches.size() == 0) begin
				if (error_count < 10)
					$display("Unexpected result at cycle %0d: index %0d kind %0d used %0d",
						cycle_count, palette_index, match_kind, entries_used);
				error_count++;
			end else begin
				want = expected_matches.pop_front();
				if (palette_index !== want.index || match_kind !== want.kind ||
						entries_used !== want.used) begin
					if (error_count < 10)
						$display({"Mismatch at cycle %0d: expected index %0d kind %0d used %0d, ",
							"got index %0d kind %0d used %0d"}, cycle_count, want.index,
							want.kind, want.used, palette_index, match_kind, entries_used);
					error_count++;
				end
			end
		end
	end

	initial begin
		palette_reply_t none_reply;
		logic [1:0] cmd;
		logic [PIXEL_W-1:0] rgb;
		bit filling;
		bit coarse;
		int unsigned extra;
		none_reply = '0;
		foreach (shadow_palette[e])
			shadow_palette[e] = '0;
		shadow_count = 1;
		directed_rows = '{
			'{CMD_MAP,     24'h000000, 1'b1, '{8'd0, KIND_EXACT,   9'd1}},
			'{CMD_NEAREST, 24'hFFFFFF, 1'b1, '{8'd0, KIND_NEAREST, 9'd1}},
			'{CMD_MAP,     24'hFFFFFF, 1'b1, '{8'd1, KIND_NEW,     9'd2}},
			'{CMD_MAP,     24'hFFFFFF, 1'b1, '{8'd1, KIND_EXACT,   9'd2}},
			'{CMD_UNUSED,  24'h5AA5C3, 1'b1, '{8'd0, KIND_NONE,    9'd2}},
			'{CMD_NEAREST, 24'hC8C8C8, 1'b1, '{8'd1, KIND_NEAREST, 9'd2}},
			'{CMD_NEAREST, 24'h000000, 1'b1, '{8'd0, KIND_NEAREST, 9'd2}},
			'{CMD_CLEAR,   24'h123456, 1'b1, '{8'd0, KIND_NONE,    9'd0}},
			'{CMD_NEAREST, 24'h0A141E, 1'b1, '{8'd0, KIND_NONE,    9'd0}},
			'{CMD_UNUSED,  24'hFFFFFF, 1'b1, '{8'd0, KIND_NONE,    9'd0}},
			'{CMD_MAP,     24'h0A0000, 1'b1, '{8'd0, KIND_NEW,     9'd1}},
			'{CMD_MAP,     24'h0C0000, 1'b1, '{8'd1, KIND_NEW,     9'd2}},
			'{CMD_NEAREST, 24'h0B0000, 1'b1, '{8'd0, KIND_NEAREST, 9'd2}},
			'{CMD_MAP,     24'h0B0000, 1'b1, '{8'd2, KIND_NEW,     9'd3}},
			'{CMD_MAP,     24'h00FF00, 1'b0, '0},
			'{CMD_MAP,     24'h0000FF, 1'b0, '0},
			'{CMD_NEAREST, 24'h808080, 1'b0, '0},
			'{CMD_MAP,     24'hFF00FF, 1'b0, '0},
			'{CMD_NEAREST, 24'h00C80A, 1'b0, '0},
			'{CMD_MAP,     24'h0A0000, 1'b0, '0},
			'{CMD_CLEAR,   24'hFFFFFF, 1'b1, '{8'd0, KIND_NONE,    9'd0}},
			'{CMD_MAP,     24'h808080, 1'b1, '{8'd0, KIND_NEW,     9'd1}}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[r])
			issue_command(directed_rows[r].cmd, directed_rows[r].rgb, directed_rows[r].fixed,
				directed_rows[r].reply);

		// Fill phases run the palette up to full and then past it, so that mapping
		// falls back on the nearest entry; short phases mix in clears and empty palettes.
		filling = 1'b1;
		while (commands_sent < TOTAL_COMMANDS) begin
			coarse = ($urandom_range(0, 2) == 0);
			if (filling) begin
				if ($urandom_range(0, 1) == 1)
					issue_command(CMD_CLEAR, random_color(1'b0), 1'b0, none_reply);
				extra = $urandom_range(20, 60);
				while (commands_sent < TOTAL_COMMANDS && extra != 0) begin
					next_random_command(1'b1, coarse, cmd, rgb);
					issue_command(cmd, rgb, 1'b0, none_reply);
					if (shadow_count == PALETTE_DEPTH)
						extra--;
				end
			end else begin
				repeat (40) begin
					if (commands_sent < TOTAL_COMMANDS) begin
						next_random_command(1'b0, coarse, cmd, rgb);
						issue_command(cmd, rgb, 1'b0, none_reply);
					end
				end
			end
			filling = !filling;
		end
		in_valid <= 1'b0;

		while (expected_matches.size() != 0)
			@(posedge clk);
		repeat (2 * (PALETTE_DEPTH + 6)) @(posedge clk);

		$display({"Sent %0d commands (%0d from the table) over %0d cycles; ",
			"the palette was filled to %0d entries %0d times."},
			commands_sent, DIRECTED_ROWS, cycle_count, PALETTE_DEPTH, fills_completed);
		$display("Results: %0d exact, %0d allocated, %0d nearest, %0d none or cleared; %0d errors.",
			kind_tally[KIND_EXACT], kind_tally[KIND_NEW], kind_tally[KIND_NEAREST],
			kind_tally[KIND_NONE], error_count);
		if (error_count == 0)
			$display("palette_color_allocator_core_tb passed");
		else
			$display("palette_color_allocator_core_tb failed");
		$finish;
	end

endmodule

@@ palette_color_allocator_core.f @@
src/pca_pkg.sv
src/pca_ram.sv
src/pca_ctrl.sv
src/pca_dp.sv
src/palette_color_allocator_core.sv
src/pca_chk.sv
tb/palette_color_allocator_core_tb.sv
